// File: hdl/hfd_pkg.sv
// Shared types, constants and the CRC-16 byte function of the HDLC deframer.
package hfd_pkg;

  // Width of the frame byte counter.
  localparam int unsigned LenW = 16;

  // Line codes and CRC polynomial.
  localparam logic [7:0]  FlagByte    = 8'h7E;
  localparam logic [7:0]  EscByte     = 8'h7D;
  localparam logic [7:0]  EscMask     = 8'h20;
  localparam logic [15:0] CrcPoly     = 16'h1021;
  localparam logic [15:0] FcsInitRst  = 16'hFFFF;
  localparam logic [15:0] MaxLenRst   = 16'd1024;
  localparam logic [7:0]  MinLenRst   = 8'd4;
  localparam logic [LenW-1:0] MinLenFloor = LenW'(4);
  localparam logic [LenW-1:0] AddrCtlLen  = LenW'(2);

  // Queue between the front and the back part.
  localparam int unsigned CmdDepth = 4;
  localparam int unsigned CmdPtrW  = $clog2(CmdDepth);
  localparam int unsigned CmdCntW  = $clog2(CmdDepth + 1);

  // Result queue at the output of the back part.
  localparam int unsigned ResDepth = 2;
  localparam int unsigned ResPtrW  = $clog2(ResDepth);
  localparam int unsigned ResCntW  = $clog2(ResDepth + 1);

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_FCS_INIT = 2'd0,
    REG_MAX_LEN  = 2'd1,
    REG_MIN_LEN  = 2'd2
  } reg_index_e;

  // Classified command from the front part.
  typedef enum logic [2:0] {
    CMD_OPEN  = 3'b001,
    CMD_CLOSE = 3'b010,
    CMD_DATA  = 3'b100
  } cmd_kind_e;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_FCS_ERR  = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_SHORT    = 2'd3
  } frame_status_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [15:0] fcs_init;
    logic [15:0] max_frame_len;
    logic [7:0]  min_frame_len;
  } cfg_t;

  typedef struct packed {
    logic          is_end;
    logic [7:0]    data_byte;
    logic [15:0]   byte_offset;
    frame_status_e frame_status;
    logic [15:0]   info_len;
  } result_t;

  // One byte through the CRC-16, MSB first, not reflected.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: hdl/hfd_front.sv
// Front part: tracks frame entry and escapes, and classifies each line byte.
module hfd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    rx_byte_i,
  output logic          cmd_valid_o,
  output hfd_pkg::cmd_t cmd_o
);

  logic inside_q, inside_d;
  logic esc_q, esc_d;

  // Classify the accepted byte and update the escape and frame state.
  always_comb begin
    inside_d    = inside_q;
    esc_d       = esc_q;
    cmd_valid_o = 1'b0;
    cmd_o.kind  = hfd_pkg::CMD_DATA;
    cmd_o.data  = rx_byte_i;
    if (accept_i) begin
      if (rx_byte_i == hfd_pkg::FlagByte) begin
        // A flag always clears a pending escape; it opens or closes a frame.
        esc_d       = 1'b0;
        inside_d    = 1'b1;
        cmd_valid_o = 1'b1;
        cmd_o.kind  = inside_q ? hfd_pkg::CMD_CLOSE : hfd_pkg::CMD_OPEN;
      end else if (inside_q) begin
        if (rx_byte_i == hfd_pkg::EscByte) begin
          esc_d = 1'b1;
        end else begin
          esc_d       = 1'b0;
          cmd_valid_o = 1'b1;
          cmd_o.data  = esc_q ? (rx_byte_i ^ hfd_pkg::EscMask) : rx_byte_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      esc_q    <= 1'b0;
    end else begin
      inside_q <= inside_d;
      esc_q    <= esc_d;
    end
  end

endmodule

// File: hdl/hfd_cmd_queue.sv
// Short command queue between the front and the back part.
module hfd_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  hfd_pkg::cmd_t wr_data_i,
  output logic          full_o,
  output logic          rd_valid_o,
  input  logic          rd_en_i,
  output hfd_pkg::cmd_t rd_data_o
);

  hfd_pkg::cmd_t                 mem_q [hfd_pkg::CmdDepth];
  logic [hfd_pkg::CmdPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [hfd_pkg::CmdCntW-1:0]   cnt_q;
  logic                          do_wr, do_rd;

  assign full_o     = (cnt_q == hfd_pkg::CmdCntW'(hfd_pkg::CmdDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_en_i && !full_o;
  assign do_rd      = rd_en_i && rd_valid_o;

  // Storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: hdl/hfd_back.sv
// Back part: delay line, CRC, length checks and the result queue.
module hfd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hfd_pkg::cfg_t    cfg_i,
  input  logic             cmd_valid_i,
  input  hfd_pkg::cmd_t    cmd_i,
  output logic             cmd_pop_o,
  output logic             res_empty_o,
  input  logic             res_pop_i,
  output hfd_pkg::result_t res_o
);

  logic [hfd_pkg::LenW-1:0] count_q, count_d;
  logic [15:0]              crc_q, crc_d;
  logic [7:0]               dly0_q, dly0_d, dly1_q, dly1_d;
  logic                     ovf_q, ovf_d;

  hfd_pkg::result_t             res_mem_q [hfd_pkg::ResDepth];
  logic [hfd_pkg::ResPtrW-1:0]  res_wr_q, res_rd_q;
  logic [hfd_pkg::ResCntW-1:0]  res_cnt_q;

  hfd_pkg::result_t res_new;
  logic             emit;
  logic             advance;
  logic             res_take;
  logic             res_room;

  assign res_empty_o = (res_cnt_q == '0);
  assign res_take    = res_pop_i && !res_empty_o;
  assign res_room    = (res_cnt_q != hfd_pkg::ResCntW'(hfd_pkg::ResDepth)) || res_take;
  assign advance     = cmd_valid_i && res_room;
  assign cmd_pop_o   = advance;
  assign res_o       = res_mem_q[res_rd_q];

  // Execute the head command: data byte, frame close or frame open.
  always_comb begin
    count_d = count_q;
    crc_d   = crc_q;
    dly0_d  = dly0_q;
    dly1_d  = dly1_q;
    ovf_d   = ovf_q;
    emit    = 1'b0;
    res_new = '0;
    if (advance) begin
      case (cmd_i.kind)
        hfd_pkg::CMD_DATA: begin
          if (!ovf_q) begin
            if (count_q >= hfd_pkg::LenW'(cfg_i.max_frame_len)) begin
              ovf_d = 1'b1;
            end else begin
              if (count_q >= hfd_pkg::AddrCtlLen) begin
                // The oldest delayed byte leaves as a data word.
                crc_d               = hfd_pkg::crc_byte(crc_q, dly0_q);
                emit                = 1'b1;
                res_new.data_byte   = dly0_q;
                res_new.byte_offset = 16'(count_q - hfd_pkg::AddrCtlLen);
              end
              dly0_d  = dly1_q;
              dly1_d  = cmd_i.data;
              count_d = count_q + 1'b1;
            end
          end
        end
        hfd_pkg::CMD_CLOSE: begin
          emit           = 1'b1;
          res_new.is_end = 1'b1;
          if (ovf_q) begin
            res_new.frame_status = hfd_pkg::ST_OVERFLOW;
          end else if ((count_q < hfd_pkg::LenW'(cfg_i.min_frame_len)) ||
                       (count_q < hfd_pkg::MinLenFloor)) begin
            res_new.frame_status = hfd_pkg::ST_SHORT;
          end else if ({dly0_q, dly1_q} == crc_q) begin
            res_new.frame_status = hfd_pkg::ST_GOOD;
            res_new.info_len     = 16'(count_q - hfd_pkg::MinLenFloor);
          end else begin
            res_new.frame_status = hfd_pkg::ST_FCS_ERR;
          end
          count_d = '0;
          crc_d   = cfg_i.fcs_init;
          dly0_d  = '0;
          dly1_d  = '0;
          ovf_d   = 1'b0;
        end
        hfd_pkg::CMD_OPEN: begin
          count_d = '0;
          crc_d   = cfg_i.fcs_init;
          dly0_d  = '0;
          dly1_d  = '0;
          ovf_d   = 1'b0;
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
  end

  // Frame state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      crc_q   <= hfd_pkg::FcsInitRst;
      dly0_q  <= '0;
      dly1_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      crc_q   <= crc_d;
      dly0_q  <= dly0_d;
      dly1_q  <= dly1_d;
      ovf_q   <= ovf_d;
    end
  end

  // Result queue storage.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_mem_q[res_wr_q] <= res_new;
    end
  end

  // Result queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wr_q  <= '0;
      res_rd_q  <= '0;
      res_cnt_q <= '0;
    end else begin
      if (emit) begin
        res_wr_q <= res_wr_q + 1'b1;
      end
      if (res_take) begin
        res_rd_q <= res_rd_q + 1'b1;
      end
      if (emit && !res_take) begin
        res_cnt_q <= res_cnt_q + 1'b1;
      end else if (res_take && !emit) begin
        res_cnt_q <= res_cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: hdl/hdlc_frame_deframer_fcs_check_unit.sv
// Top level of the HDLC deframer with CRC-16 frame check.
//
//   Channel   Handshake                  Payload
//   input     push / full                rx_byte_i
//   result    empty / pop                is_end_o, data_byte_o, byte_offset_o,
//                                        frame_status_o, info_len_o
//   config    cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One byte per cycle is sustained while full stays low. A byte is classified in
// its accept cycle and written into the command queue; the back executes it from
// the queue head once the result queue has room and queues its result word.
// Reset clears frame, escape and queue state and loads the register defaults.
// The command queue holds four words and the result queue two, so pop stalls
// reach push only after both fill. Configuration writes are always ready.
module hdlc_frame_deframer_fcs_check_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic        is_end_o,
  output logic [7:0]  data_byte_o,
  output logic [15:0] byte_offset_o,
  output logic [1:0]  frame_status_o,
  output logic [15:0] info_len_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  hfd_pkg::cfg_t    cfg_q;
  hfd_pkg::cmd_t    fr_cmd, q_cmd;
  hfd_pkg::result_t res;
  logic             fr_valid, q_valid, q_pop, accept;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fcs_init      <= hfd_pkg::FcsInitRst;
      cfg_q.max_frame_len <= hfd_pkg::MaxLenRst;
      cfg_q.min_frame_len <= hfd_pkg::MinLenRst;
    end else if (cfg_valid_i) begin
      case (hfd_pkg::reg_index_e'(cfg_index_i))
        hfd_pkg::REG_FCS_INIT: cfg_q.fcs_init      <= cfg_data_i;
        hfd_pkg::REG_MAX_LEN:  cfg_q.max_frame_len <= cfg_data_i;
        hfd_pkg::REG_MIN_LEN:  cfg_q.min_frame_len <= cfg_data_i[7:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  hfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .cmd_valid_o (fr_valid),
    .cmd_o       (fr_cmd)
  );

  hfd_cmd_queue u_cmd_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (fr_valid),
    .wr_data_i  (fr_cmd),
    .full_o     (full),
    .rd_valid_o (q_valid),
    .rd_en_i    (q_pop),
    .rd_data_o  (q_cmd)
  );

  hfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .res_empty_o (empty),
    .res_pop_i   (pop),
    .res_o       (res)
  );

  assign is_end_o       = res.is_end;
  assign data_byte_o    = res.data_byte;
  assign byte_offset_o  = res.byte_offset;
  assign frame_status_o = res.frame_status;
  assign info_len_o     = res.info_len;

endmodule

// File: tb/hdlc_deframer_checker.sv
// Checker for the HDLC deframer: predicts every result word and compares it.
module hdlc_deframer_checker
  import hfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic        is_end_i,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] byte_offset_i,
  input  logic [1:0]  frame_status_i,
  input  logic [15:0] info_len_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          pending_o,
  output int          fail_count_o
);

  timeunit 1ns;
  timeprecision 1ps;

  // Register copies, as last written on the configuration channel.
  logic [15:0] fcs_init_cfg;
  logic [15:0] max_len_cfg;
  logic [7:0]  min_len_cfg;

  // Deframer state.
  logic            in_frame;
  logic            esc_pend;
  logic [LenW-1:0] cnt;
  logic [15:0]     crc;
  logic [7:0]      dly [2];
  logic            ovf;

  // Result words still owed by the block, oldest first.
  result_t frame_words [$];
  int      n_fail = 0;

  assign fail_count_o = n_fail;

  task automatic report_mismatch(input string msg);
    n_fail++;
    if (n_fail <= 40) begin
      $display("%0t ns: mismatch: %s", $realtime, msg);
    end
  endtask

  // CRC-16, polynomial 0x1021, one bit of the byte per step, MSB first.
  function automatic logic [15:0] fcs_update(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CrcPoly;
      end
    end
    return r;
  endfunction

  function automatic void restart_frame();
    cnt = '0;
    crc = fcs_init_cfg;
    dly[0] = 8'h00;
    dly[1] = 8'h00;
    ovf = 1'b0;
  endfunction

  // Runs one line byte through the deframer and queues the word it causes.
  task automatic deframe_byte(input logic [7:0] raw);
    logic [7:0] b;
    result_t    w;
    b = raw;
    w = '0;
    if (b == FlagByte) begin
      esc_pend = 1'b0;
      if (!in_frame) begin
        in_frame = 1'b1;
        restart_frame();
      end else begin
        // Closing flag: status in priority order, then the next frame opens.
        w.is_end = 1'b1;
        if (ovf) begin
          w.frame_status = ST_OVERFLOW;
        end else if (cnt < min_len_cfg || cnt < MinLenFloor) begin
          w.frame_status = ST_SHORT;
        end else if ({dly[0], dly[1]} == crc) begin
          w.frame_status = ST_GOOD;
          w.info_len = cnt - MinLenFloor;
        end else begin
          w.frame_status = ST_FCS_ERR;
        end
        frame_words.push_back(w);
        restart_frame();
      end
    end else if (in_frame) begin
      if (b == EscByte) begin
        esc_pend = 1'b1;
      end else begin
        if (esc_pend) begin
          b = b ^ EscMask;
          esc_pend = 1'b0;
        end
        if (!ovf) begin
          if (cnt >= max_len_cfg) begin
            ovf = 1'b1;
          end else begin
            // The byte leaving the two-byte delay is emitted and checked.
            if (cnt >= AddrCtlLen) begin
              crc = fcs_update(crc, dly[0]);
              w.data_byte = dly[0];
              w.byte_offset = cnt - AddrCtlLen;
              frame_words.push_back(w);
            end
            dly[0] = dly[1];
            dly[1] = b;
            cnt = cnt + 1'b1;
          end
        end
      end
    end
  endtask

  task automatic check_word();
    result_t want;
    if (frame_words.size() == 0) begin
      report_mismatch($sformatf("unexpected word is_end=%0d data=%02h offset=%0d status=%0d len=%0d",
                                is_end_i, data_byte_i, byte_offset_i, frame_status_i,
                                info_len_i));
    end else begin
      want = frame_words.pop_front();
      if (is_end_i !== want.is_end) begin
        report_mismatch($sformatf("is_end %b, expected %b", is_end_i, want.is_end));
      end
      if (data_byte_i !== want.data_byte) begin
        report_mismatch($sformatf("data_byte %02h, expected %02h", data_byte_i, want.data_byte));
      end
      if (byte_offset_i !== want.byte_offset) begin
        report_mismatch($sformatf("byte_offset %0d, expected %0d", byte_offset_i,
                                  want.byte_offset));
      end
      if (frame_status_i !== want.frame_status) begin
        report_mismatch($sformatf("frame_status %0d, expected %0d", frame_status_i,
                                  want.frame_status));
      end
      if (info_len_i !== want.info_len) begin
        report_mismatch($sformatf("info_len %0d, expected %0d", info_len_i, want.info_len));
      end
    end
  endtask

  // Watch all three channels at every edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcs_init_cfg = FcsInitRst;
      max_len_cfg = MaxLenRst;
      min_len_cfg = MinLenRst;
      in_frame = 1'b0;
      esc_pend = 1'b0;
      restart_frame();
      frame_words.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_index_e'(cfg_index_i))
          REG_FCS_INIT: fcs_init_cfg = cfg_data_i;
          REG_MAX_LEN:  max_len_cfg = cfg_data_i;
          REG_MIN_LEN:  min_len_cfg = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (push_i && !full_i) begin
        deframe_byte(rx_byte_i);
      end
      if (pop_i && !empty_i) begin
        check_word();
      end
      pending_o <= frame_words.size();
    end
  end

endmodule

// File: tb/hdlc_frame_deframer_fcs_check_unit_tb.sv
// Testbench top for the HDLC deframer: stimulus, idling, watchdog and verdict.
module hdlc_frame_deframer_fcs_check_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import hfd_pkg::*;

  localparam int IdleLimit = 3000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic [7:0]  rx_byte = 8'h00;
  logic        pop = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = REG_FCS_INIT;
  logic [15:0] cfg_data = 16'h0000;

  logic        full;
  logic        empty;
  logic        is_end;
  logic [7:0]  data_byte;
  logic [15:0] byte_offset;
  logic [1:0]  frame_status;
  logic [15:0] info_len;
  logic        cfg_ready;

  int pending;
  int fail_count;
  int n_sent = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;

  // Settings the block currently holds, for building good frames.
  logic [15:0] cur_fcs_init = FcsInitRst;
  logic [15:0] cur_max_len = MaxLenRst;
  logic [7:0]  cur_min_len = MinLenRst;

  // Address, control and information bytes of the frame being built.
  logic [7:0] frame_body [$];

  hdlc_frame_deframer_fcs_check_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .rx_byte_i      (rx_byte),
    .empty          (empty),
    .pop            (pop),
    .is_end_o       (is_end),
    .data_byte_o    (data_byte),
    .byte_offset_o  (byte_offset),
    .frame_status_o (frame_status),
    .info_len_o     (info_len),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  hdlc_deframer_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_i         (full),
    .rx_byte_i      (rx_byte),
    .empty_i        (empty),
    .pop_i          (pop),
    .is_end_i       (is_end),
    .data_byte_i    (data_byte),
    .byte_offset_i  (byte_offset),
    .frame_status_i (frame_status),
    .info_len_i     (info_len),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Gap lengths: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Random frame byte, leaning toward flag, escape and edge values.
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 15))
      0: return FlagByte;
      1: return EscByte;
      2: return FlagByte ^ EscMask;
      3: return 8'h00;
      4: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int pick_info_len();
    if (cur_min_len > 8'd20 && $urandom_range(0, 2) == 0) begin
      return int'(cur_min_len) - 4 + $urandom_range(0, 4);
    end
    if ($urandom_range(0, 6) != 0) begin
      return $urandom_range(0, 8);
    end
    return $urandom_range(9, 40);
  endfunction

  // One line byte on the input channel; push stays high into the next call.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    rx_byte <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    n_sent++;
  endtask

  // Frame byte with escaping where needed, and now and then where not.
  task automatic send_stuffed(input logic [7:0] b);
    logic [7:0] flipped;
    flipped = b ^ EscMask;
    if (b == FlagByte || b == EscByte ||
        (flipped != FlagByte && flipped != EscByte && $urandom_range(0, 19) == 0)) begin
      send_byte(EscByte);
      send_byte(flipped);
    end else begin
      send_byte(b);
    end
  endtask

  task automatic fill_body(input int info_n);
    frame_body.delete();
    repeat (info_n + 2) frame_body.push_back(rand_byte());
  endtask

  // Sends frame_body with its FCS and a closing flag.
  task automatic send_frame(input bit bad_fcs, input bit esc_close);
    logic [15:0] fcs;
    fcs = cur_fcs_init;
    foreach (frame_body[i]) begin
      fcs = crc_byte(fcs, frame_body[i]);
      send_stuffed(frame_body[i]);
    end
    if (bad_fcs) begin
      fcs = fcs ^ (16'h0001 << $urandom_range(0, 15));
    end
    send_stuffed(fcs[15:8]);
    send_stuffed(fcs[7:0]);
    if (esc_close) begin
      send_byte(EscByte);
    end
    send_byte(FlagByte);
  endtask

  // One random frame: mostly well formed, the rest broken or noise.
  task automatic random_frame();
    int r;
    r = $urandom_range(0, 99);
    calm = ($urandom_range(0, 9) == 0);
    if (r < 60) begin
      fill_body(pick_info_len());
      send_frame(1'b0, 1'b0);
    end else if (r < 70) begin
      fill_body(pick_info_len());
      send_frame(1'b1, 1'b0);
    end else if (r < 78) begin
      repeat ($urandom_range(0, 3)) send_stuffed(rand_byte());
      send_byte(FlagByte);
    end else if (r < 85) begin
      repeat ($urandom_range(1, 12)) send_byte(rand_byte());
      send_byte(FlagByte);
    end else if (r < 90) begin
      fill_body(pick_info_len());
      send_frame(1'b0, 1'b1);
    end else if (r < 95) begin
      send_byte(FlagByte);
      fill_body(pick_info_len());
      send_frame(1'b0, 1'b0);
    end else begin
      // Just past the length limit where that is cheap to reach.
      if (cur_max_len <= 16'd64) begin
        fill_body(int'(cur_max_len) - 4 + $urandom_range(1, 3));
      end else begin
        fill_body(pick_info_len());
      end
      send_frame(1'b0, 1'b0);
    end
  endtask

  // Hold the sender until every owed word is out and the block is quiet.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_word(input reg_index_e idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
  endtask

  // New settings, then random frames until the byte count reaches the target.
  task automatic run_phase(input logic [15:0] init_v, input logic [15:0] max_v,
                           input logic [7:0] min_v, input int target);
    drain();
    cfg_word(REG_FCS_INIT, init_v);
    cfg_word(REG_MAX_LEN, max_v);
    cfg_word(REG_MIN_LEN, {8'h00, min_v});
    cfg_valid <= 1'b0;
    cur_fcs_init = init_v;
    cur_max_len = max_v;
    cur_min_len = min_v;
    // The open frame restarted with the old FCS start value; restart it.
    send_byte(FlagByte);
    while (n_sent < target) random_frame();
  endtask

  // Result side: pops with random stalls.
  initial begin
    int gap;
    wait (rst_ni);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
    end
  end

  // Watchdog on cycles in which no channel moves a word.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("hdlc_frame_deframer_fcs_check_unit_tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Outside a frame everything but a flag is ignored, escapes too.
    send_byte(EscByte);
    send_byte(8'hA5);
    send_byte(8'h00);
    send_byte(FlagByte);
    // Good frame carrying a flag and an escape in its information field.
    frame_body.delete();
    frame_body.push_back(8'hFF);
    frame_body.push_back(8'h03);
    frame_body.push_back(FlagByte);
    frame_body.push_back(EscByte);
    frame_body.push_back(8'h00);
    send_frame(1'b0, 1'b0);
    // A flag right after an escape still closes the frame.
    send_byte(EscByte);
    send_byte(FlagByte);
    // A second escape keeps the escape pending.
    send_byte(EscByte);
    send_byte(EscByte);
    send_byte(FlagByte ^ EscMask);
    send_byte(FlagByte);
    // Shortest frame with a wrong FCS.
    frame_body.delete();
    frame_body.push_back(8'h00);
    frame_body.push_back(8'hFF);
    send_frame(1'b1, 1'b0);

    // Reset settings first, then the extremes, then a random middle.
    while (n_sent < 600) random_frame();
    run_phase(16'h0000, 16'd4, 8'd4, 900);
    run_phase(16'hFFFF, 16'hFFFF, 8'd255, 1400);
    run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(5, 60)),
              8'($urandom_range(4, 24)), 1950);

    drain();
    if (fail_count == 0) begin
      $display("hdlc_frame_deframer_fcs_check_unit_tb OK");
    end else begin
      $display("hdlc_frame_deframer_fcs_check_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
